// ===== hw/rtl/pts_pkg.sv =====
// Package for the priority task scheduler: command codes, operation classes,
// the queue item type and fixed field widths. No dependencies.
package pts_pkg;

    localparam int CMD_W      = 3;
    localparam int PRIO_FW    = 5;
    localparam int TICKS_FW   = 32;
    localparam int LOCK_W     = 8;
    localparam int MAP_FW     = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [LOCK_W-1:0] LOCK_MAX = 8'd255;

    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELAY  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LOCK   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_UNLOCK = 3'd5;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_START,
        OP_TICK,
        OP_DELAY,
        OP_LOCK,
        OP_UNLOCK,
        OP_IGNORE
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic                prio_ok;
        logic [PRIO_FW-1:0]  prio;
        logic [TICKS_FW-1:0] ticks;
    } item_t;

endpackage

// ===== hw/rtl/pts_if.sv =====
// Channel interfaces of the priority task scheduler: command in, result out.
// Depends on pts_pkg for field widths.
interface pts_cmd_if
    import pts_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [PRIO_FW-1:0]  task_prio;
    logic [TICKS_FW-1:0] delay_ticks;

    modport source (output valid, output cmd, output task_prio, output delay_ticks,
                    input ready);
    modport sink   (input valid, input cmd, input task_prio, input delay_ticks,
                    output ready);
endinterface

interface pts_res_if
    import pts_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               switch_now;
    logic [PRIO_FW-1:0] next_task;
    logic [LOCK_W-1:0]  lock_count;
    logic [MAP_FW-1:0]  ready_map;

    modport source (output valid, output switch_now, output next_task,
                    output lock_count, output ready_map, input ready);
    modport sink   (input valid, input switch_now, input next_task,
                    input lock_count, input ready_map, output ready);
endinterface

// ===== hw/rtl/priority_task_scheduler_with_delays.sv =====
// Top level of the priority task scheduler with per-slot delays.
// Depends on pts_pkg, pts_if, pts_front, pts_queue and pts_back.
//
//   channel  dir  payload                                       transaction
//   cmd_ch   in   cmd, task_prio, delay_ticks                   valid & ready
//   res_ch   out  switch_now, next_task, lock_count, ready_map  valid & ready
//
// Start, tick, delay and an unlock that reaches zero walk the delay counter
// memory one slot per cycle; add, lock, other unlocks and undefined commands
// skip the walk.
// Reset clears ready and delayed maps, running slot and lock count.
// A two-entry queue parts the front from the back; a stalled result holds
// in the output register while the front keeps accepting until the queue fills.
module priority_task_scheduler_with_delays
    import pts_pkg::*;
#(
    parameter int NUM_PRIOS  = 32,
    parameter int TICK_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    pts_cmd_if.sink   cmd_ch,
    pts_res_if.source res_ch
);

    logic  q_full;
    logic  q_push;
    item_t q_push_item;
    logic  q_valid;
    item_t q_item;
    logic  q_pop;

    pts_front #(
        .NUM_PRIOS  (NUM_PRIOS),
        .TICK_WIDTH (TICK_WIDTH)
    ) u_front (
        .cmd_ch (cmd_ch),
        .q_full (q_full),
        .q_push (q_push),
        .q_item (q_push_item)
    );

    pts_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop_item  (q_item),
        .pop       (q_pop)
    );

    pts_back #(
        .NUM_PRIOS  (NUM_PRIOS),
        .TICK_WIDTH (TICK_WIDTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .res_ch  (res_ch)
    );

endmodule

// ===== hw/rtl/pts_front.sv =====
// Front end: accepts commands and classifies them into queue items.
// Depends on pts_pkg and pts_cmd_if.
module pts_front
    import pts_pkg::*;
#(
    parameter int NUM_PRIOS  = 32,
    parameter int TICK_WIDTH = 32
) (
    pts_cmd_if.sink   cmd_ch,
    input  logic      q_full,
    output logic      q_push,
    output item_t     q_item
);

    logic [TICK_WIDTH-1:0] ticks_masked;

    assign cmd_ch.ready = !q_full;
    assign q_push       = cmd_ch.valid && !q_full;
    assign ticks_masked = cmd_ch.delay_ticks[TICK_WIDTH-1:0];

    always_comb
    begin
        q_item.prio    = cmd_ch.task_prio;
        q_item.prio_ok = ({2'b00, cmd_ch.task_prio} < 7'(NUM_PRIOS));
        // a delay of zero sleeps for one tick
        if (ticks_masked == '0)
        begin
            q_item.ticks = TICKS_FW'(1);
        end
        else
        begin
            q_item.ticks = TICKS_FW'(ticks_masked);
        end
        case (cmd_ch.cmd)
            CMD_ADD:    q_item.op = OP_ADD;
            CMD_START:  q_item.op = OP_START;
            CMD_TICK:   q_item.op = OP_TICK;
            CMD_DELAY:  q_item.op = OP_DELAY;
            CMD_LOCK:   q_item.op = OP_LOCK;
            CMD_UNLOCK: q_item.op = OP_UNLOCK;
            default:    q_item.op = OP_IGNORE;
        endcase
    end

endmodule

// ===== hw/rtl/pts_queue.sv =====
// Short queue of classified items between front and back end.
// Depends on pts_pkg.
module pts_queue
    import pts_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    output logic  pop_valid,
    output item_t pop_item,
    input  logic  pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    item_t              entries [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]     count_reg, count_next;
    logic               do_push, do_pop;

    assign full      = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = entries[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hw/rtl/pts_back.sv =====
// Back end: executes queued commands, walks the delay counter memory one slot
// per cycle, picks the lowest ready slot and registers the result.
// Depends on pts_pkg and pts_res_if.
module pts_back
    import pts_pkg::*;
#(
    parameter int NUM_PRIOS  = 32,
    parameter int TICK_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        q_pop,
    pts_res_if.source   res_ch
);

    localparam int PRIO_W = $clog2(NUM_PRIOS);
    localparam logic [PRIO_W-1:0] LAST_SLOT = PRIO_W'(NUM_PRIOS - 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXEC   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_DRAIN  = 5'b01000,
        S_RESULT = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    item_t                 item_reg, item_next;
    logic [PRIO_W-1:0]     idx_reg, idx_next;
    logic                  pend_reg, pend_next;
    logic [PRIO_W-1:0]     pend_idx_reg, pend_idx_next;
    logic [TICK_WIDTH-1:0] rd_data_reg;
    logic [NUM_PRIOS-1:0]  ready_reg, ready_next;
    logic [NUM_PRIOS-1:0]  delayed_reg, delayed_next;
    logic [PRIO_W-1:0]     running_reg, running_next;
    logic [LOCK_W-1:0]     lock_reg, lock_next;
    logic                  found_reg, found_next;
    logic [PRIO_W-1:0]     best_reg, best_next;
    logic                  sched_reg, sched_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  switch_reg, switch_next;
    logic [PRIO_FW-1:0]    task_reg, task_next;
    logic [LOCK_W-1:0]     lockc_reg, lockc_next;
    logic [MAP_FW-1:0]     map_reg, map_next;

    logic [TICK_WIDTH-1:0] counters [NUM_PRIOS];
    logic                  mem_we;
    logic [PRIO_W-1:0]     mem_waddr;
    logic [TICK_WIDTH-1:0] mem_wdata;
    logic                  mem_re;

    logic [PRIO_W+PRIO_FW-1:0] prio_pad;
    logic [PRIO_W-1:0]         add_slot;
    logic [TICK_WIDTH-1:0]     dec_val;
    logic                      expire;
    logic                      now_ready;
    logic                      sw;
    logic                      out_free;
    logic [NUM_PRIOS+MAP_FW-1:0]   map_pad;
    logic [PRIO_W+PRIO_FW-1:0]     run_pad;

    assign prio_pad = {{PRIO_W{1'b0}}, item_reg.prio};
    assign add_slot = prio_pad[PRIO_W-1:0];
    assign dec_val  = rd_data_reg - 1'b1;
    assign out_free = !out_valid_reg || res_ch.ready;
    assign mem_re   = (state_reg == S_SCAN);

    assign res_ch.valid      = out_valid_reg;
    assign res_ch.switch_now = switch_reg;
    assign res_ch.next_task  = task_reg;
    assign res_ch.lock_count = lockc_reg;
    assign res_ch.ready_map  = map_reg;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        pend_idx_next  = idx_reg;
        ready_next     = ready_reg;
        delayed_next   = delayed_reg;
        running_next   = running_reg;
        lock_next      = lock_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        sched_next     = sched_reg;
        out_valid_next = out_valid_reg;
        switch_next    = switch_reg;
        task_next      = task_reg;
        lockc_next     = lockc_reg;
        map_next       = map_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = running_reg;
        mem_wdata      = item_reg.ticks[TICK_WIDTH-1:0];
        expire         = 1'b0;
        now_ready      = 1'b0;
        sw             = 1'b0;
        map_pad        = '0;
        run_pad        = '0;

        if (out_valid_reg && res_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        // process the slot whose counter was read last cycle
        if (pend_reg)
        begin
            if (item_reg.op == OP_TICK && delayed_reg[pend_idx_reg])
            begin
                mem_we    = 1'b1;
                mem_waddr = pend_idx_reg;
                mem_wdata = dec_val;
                if (dec_val == '0)
                begin
                    expire = 1'b1;
                    delayed_next[pend_idx_reg] = 1'b0;
                    ready_next[pend_idx_reg]   = 1'b1;
                end
            end
            now_ready = ready_reg[pend_idx_reg] | expire;
            if (now_ready && !found_reg)
            begin
                found_next = 1'b1;
                best_next  = pend_idx_reg;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    item_next  = q_item;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                idx_next   = '0;
                found_next = 1'b0;
                sched_next = 1'b0;
                state_next = S_RESULT;
                case (item_reg.op)
                    OP_ADD:
                    begin
                        if (item_reg.prio_ok)
                        begin
                            ready_next[add_slot]   = 1'b1;
                            delayed_next[add_slot] = 1'b0;
                        end
                    end
                    OP_START, OP_TICK:
                    begin
                        state_next = S_SCAN;
                    end
                    OP_DELAY:
                    begin
                        mem_we                    = 1'b1;
                        delayed_next[running_reg] = 1'b1;
                        ready_next[running_reg]   = 1'b0;
                        state_next                = S_SCAN;
                    end
                    OP_LOCK:
                    begin
                        if (lock_reg != LOCK_MAX)
                        begin
                            lock_next = lock_reg + 1'b1;
                        end
                    end
                    OP_UNLOCK:
                    begin
                        if (lock_reg != '0)
                        begin
                            lock_next = lock_reg - 1'b1;
                            if (lock_reg == LOCK_W'(1))
                            begin
                                sched_next = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_SCAN:
            begin
                pend_next     = 1'b1;
                pend_idx_next = idx_reg;
                if (idx_reg == LAST_SLOT)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    case (item_reg.op)
                        OP_START:
                        begin
                            if (found_reg)
                            begin
                                running_next = best_reg;
                                sw           = 1'b1;
                            end
                        end
                        OP_TICK, OP_DELAY:
                        begin
                            if (lock_reg == '0 && found_reg && best_reg != running_reg)
                            begin
                                running_next = best_reg;
                                sw           = 1'b1;
                            end
                        end
                        OP_UNLOCK:
                        begin
                            if (sched_reg && found_reg && best_reg != running_reg)
                            begin
                                running_next = best_reg;
                                sw           = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    map_pad        = {{MAP_FW{1'b0}}, ready_reg};
                    run_pad        = {{PRIO_FW{1'b0}}, running_next};
                    out_valid_next = 1'b1;
                    switch_next    = sw;
                    task_next      = run_pad[PRIO_FW-1:0];
                    lockc_next     = lock_reg;
                    map_next       = map_pad[MAP_FW-1:0];
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_idx_reg  <= '0;
            ready_reg     <= '0;
            delayed_reg   <= '0;
            running_reg   <= '0;
            lock_reg      <= '0;
            found_reg     <= 1'b0;
            best_reg      <= '0;
            sched_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            pend_idx_reg  <= pend_idx_next;
            ready_reg     <= ready_next;
            delayed_reg   <= delayed_next;
            running_reg   <= running_next;
            lock_reg      <= lock_next;
            found_reg     <= found_next;
            best_reg      <= best_next;
            sched_reg     <= sched_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        switch_reg <= switch_next;
        task_reg   <= task_next;
        lockc_reg  <= lockc_next;
        map_reg    <= map_next;
    end

    // delay counter memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            counters[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= counters[idx_reg];
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// Testbench for priority_task_scheduler_with_delays: sends scheduler commands,
// predicts each result and checks it. Depends on pts_pkg, pts_if and the RTL.
module tb_top;
    import pts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS   = 32;
    localparam int OP_LATENCY  = NUM_SLOTS + 4;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_LEN    = 400;
    localparam int IDLE_PCT    = 11;

    localparam logic [CMD_W-1:0] CMD_UNDEF_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNDEF_HI = 3'd7;

    typedef struct packed {
        logic               switch_now;
        logic [PRIO_FW-1:0] next_task;
        logic [LOCK_W-1:0]  lock_count;
        logic [MAP_FW-1:0]  ready_map;
    } sched_res_t;

    logic clk;
    logic rst_n;

    pts_cmd_if cmd_ch();
    pts_res_if res_ch();

    priority_task_scheduler_with_delays u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd_ch (cmd_ch),
        .res_ch (res_ch)
    );

    // scheduler state as the block should hold it
    logic [NUM_SLOTS-1:0] ready_slots;
    logic [NUM_SLOTS-1:0] sleeping_slots;
    logic [TICKS_FW-1:0]  sleep_count [NUM_SLOTS];
    logic [PRIO_FW-1:0]   running_slot;
    logic [LOCK_W-1:0]    lock_depth;

    sched_res_t sched_results_q[$];
    int         mismatch_count = 0;
    int         cycle_count    = 0;
    bit         gaps_on        = 1'b1;
    bit         hold_request   = 1'b0;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    function automatic logic [PRIO_FW-1:0] first_ready(input logic [NUM_SLOTS-1:0] map);
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (map[i]) return i[PRIO_FW-1:0];
        end
        return '0;
    endfunction

    // pick the lowest ready slot when unlocked; return 1 on a switch
    function automatic logic reschedule_slot();
        logic [PRIO_FW-1:0] best;
        if (lock_depth != 0 || ready_slots == 0) return 1'b0;
        best = first_ready(ready_slots);
        if (best == running_slot) return 1'b0;
        running_slot = best;
        return 1'b1;
    endfunction

    function automatic void schedule_step(input logic [CMD_W-1:0]    cmd,
                                          input logic [PRIO_FW-1:0]  prio,
                                          input logic [TICKS_FW-1:0] ticks);
        sched_res_t res;
        logic       sw;
        sw = 1'b0;
        case (cmd)
            CMD_ADD: begin
                ready_slots[prio]    = 1'b1;
                sleeping_slots[prio] = 1'b0;
                sleep_count[prio]    = '0;
            end
            CMD_START: begin
                if (ready_slots != 0) begin
                    running_slot = first_ready(ready_slots);
                    sw = 1'b1;
                end
            end
            CMD_TICK: begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (sleeping_slots[i]) begin
                        sleep_count[i] = sleep_count[i] - 1'b1;
                        if (sleep_count[i] == 0) begin
                            sleeping_slots[i] = 1'b0;
                            ready_slots[i]    = 1'b1;
                        end
                    end
                end
                sw = reschedule_slot();
            end
            CMD_DELAY: begin
                // a zero delay sleeps for one tick
                sleep_count[running_slot]    = (ticks == 0) ? 1 : ticks;
                sleeping_slots[running_slot] = 1'b1;
                ready_slots[running_slot]    = 1'b0;
                sw = reschedule_slot();
            end
            CMD_LOCK: begin
                if (lock_depth != LOCK_MAX) lock_depth++;
            end
            CMD_UNLOCK: begin
                if (lock_depth != 0) begin
                    lock_depth--;
                    if (lock_depth == 0) sw = reschedule_slot();
                end
            end
            default: ;
        endcase
        res.switch_now = sw;
        res.next_task  = running_slot;
        res.lock_count = lock_depth;
        res.ready_map  = ready_slots;
        sched_results_q.push_back(res);
    endfunction

    // one command transaction; returns at the falling edge after acceptance
    task automatic send_cmd(input logic [CMD_W-1:0]    cmd,
                            input logic [PRIO_FW-1:0]  prio,
                            input logic [TICKS_FW-1:0] ticks);
        while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.cmd         <= cmd;
        cmd_ch.task_prio   <= prio;
        cmd_ch.delay_ticks <= ticks;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
        schedule_step(cmd, prio, ticks);
        @(negedge clk);
    endtask

    task automatic send_random_cmd();
        int                  pick;
        int                  tsel;
        logic [CMD_W-1:0]    cmd;
        logic [TICKS_FW-1:0] ticks;
        pick = $urandom_range(99);
        if (pick < 22)      cmd = CMD_ADD;
        else if (pick < 27) cmd = CMD_START;
        else if (pick < 55) cmd = CMD_TICK;
        else if (pick < 76) cmd = CMD_DELAY;
        else if (pick < 86) cmd = CMD_LOCK;
        else if (pick < 97) cmd = CMD_UNLOCK;
        else if (pick < 99) cmd = CMD_UNDEF_LO;
        else                cmd = CMD_UNDEF_HI;
        // mostly short sleeps so that slots wake up again
        tsel = $urandom_range(9);
        if (tsel < 6)       ticks = $urandom_range(0, 4);
        else if (tsel < 8)  ticks = $urandom_range(5, 40);
        else if (tsel == 8) ticks = $urandom();
        else                ticks = $urandom_range(1) ? '1 : '0;
        send_cmd(cmd, PRIO_FW'($urandom_range(NUM_SLOTS - 1)), ticks);
    endtask

    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        while (sched_results_q.size() != 0) @(posedge clk);
        repeat (OP_LATENCY) @(posedge clk);
        @(negedge clk);
    endtask

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_LEN;
            end
            if (hold_left > 0) begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                res_ch.ready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
            end
        end
    end

    always @(posedge clk) begin
        sched_res_t want;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            if (sched_results_q.size() == 0) begin
                report_mismatch("result with no command outstanding");
            end else begin
                want = sched_results_q.pop_front();
                if (res_ch.switch_now !== want.switch_now)
                    report_mismatch($sformatf("switch_now %b, want %b",
                                              res_ch.switch_now, want.switch_now));
                if (res_ch.next_task !== want.next_task)
                    report_mismatch($sformatf("next_task %0d, want %0d",
                                              res_ch.next_task, want.next_task));
                if (res_ch.lock_count !== want.lock_count)
                    report_mismatch($sformatf("lock_count %0d, want %0d",
                                              res_ch.lock_count, want.lock_count));
                if (res_ch.ready_map !== want.ready_map)
                    report_mismatch($sformatf("ready_map %h, want %h",
                                              res_ch.ready_map, want.ready_map));
            end
        end
    end

    // nothing ready: start, tick and delay find no slot; unlock at zero; bad opcodes
    task automatic test_empty_scheduler();
        send_cmd(CMD_START, 5'd0, 32'd0);
        send_cmd(CMD_TICK, 5'd31, 32'hFFFF_FFFF);
        send_cmd(CMD_DELAY, 5'd0, 32'd0);
        send_cmd(CMD_TICK, 5'd0, 32'd0);
        send_cmd(CMD_UNLOCK, 5'd0, 32'd0);
        send_cmd(CMD_UNDEF_LO, 5'd31, 32'hFFFF_FFFF);
        send_cmd(CMD_UNDEF_HI, 5'd17, 32'h5555_AAAA);
    endtask

    task automatic test_basic_scheduling();
        send_cmd(CMD_ADD, 5'd31, 32'hFFFF_FFFF);
        send_cmd(CMD_ADD, 5'd5, 32'd0);
        send_cmd(CMD_START, 5'd0, 32'd0);
        send_cmd(CMD_DELAY, 5'd0, 32'hFFFF_FFFF);
        send_cmd(CMD_DELAY, 5'd0, 32'd2);
        send_cmd(CMD_TICK, 5'd0, 32'd0);
        send_cmd(CMD_TICK, 5'd0, 32'd0);
        // re-adding cancels the long sleep of slot 5
        send_cmd(CMD_ADD, 5'd5, 32'd0);
        send_cmd(CMD_DELAY, 5'd0, 32'h8000_0000);
        send_cmd(CMD_ADD, 5'd0, 32'd7);
    endtask

    // while locked a delay still sleeps the slot but never switches
    task automatic test_lock_paths();
        send_cmd(CMD_LOCK, 5'd0, 32'd0);
        send_cmd(CMD_LOCK, 5'd0, 32'd0);
        send_cmd(CMD_TICK, 5'd0, 32'd0);
        send_cmd(CMD_DELAY, 5'd0, 32'd1);
        send_cmd(CMD_UNLOCK, 5'd0, 32'd0);
        send_cmd(CMD_UNLOCK, 5'd0, 32'd0);
    endtask

    task automatic test_lock_saturation();
        gaps_on = 1'b0;
        repeat (int'(LOCK_MAX) + 3)
            send_cmd(CMD_LOCK, PRIO_FW'($urandom_range(31)), $urandom());
        send_cmd(CMD_TICK, 5'd0, 32'd0);
        send_cmd(CMD_ADD, 5'd1, 32'd0);
        repeat (int'(LOCK_MAX) + 3)
            send_cmd(CMD_UNLOCK, PRIO_FW'($urandom_range(31)), $urandom());
        gaps_on = 1'b1;
    endtask

    // stall the result side long enough that the block stops taking commands
    task automatic test_backpressure();
        hold_request = 1'b1;
        repeat (40) send_random_cmd();
    endtask

    task automatic test_random_traffic();
        repeat (1150) send_random_cmd();
    endtask

    initial begin
        rst_n              = 1'b0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.cmd         = '0;
        cmd_ch.task_prio   = '0;
        cmd_ch.delay_ticks = '0;
        ready_slots        = '0;
        sleeping_slots     = '0;
        running_slot       = '0;
        lock_depth         = '0;
        for (int i = 0; i < NUM_SLOTS; i++) sleep_count[i] = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_scheduler();
        test_basic_scheduling();
        test_lock_paths();
        test_lock_saturation();
        test_backpressure();
        test_random_traffic();
        wait_drained();

        if (mismatch_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/pts_pkg.sv
hw/rtl/pts_if.sv
hw/rtl/pts_front.sv
hw/rtl/pts_queue.sv
hw/rtl/pts_back.sv
hw/rtl/priority_task_scheduler_with_delays.sv
tb/tb_top.sv
